/* hw/rtl/rcppm_pkg.sv */
`timescale 1ns / 1ps

package rcppm_pkg;

    // Width of the interval countdown in ticks
    localparam int CNT_W = 22;

    // Register map
    localparam logic [2:0] REG_MIN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_MAX_WIDTH   = 3'd1;
    localparam logic [2:0] REG_GAP_WIDTH   = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd3;
    localparam logic [2:0] REG_TRIM_CENTER = 3'd4;

    // Register reset values (microseconds)
    localparam int RST_MIN_US   = 700;
    localparam int RST_MAX_US   = 1700;
    localparam int RST_GAP_US   = 300;
    localparam int RST_FRAME_US = 22500;
    localparam int RST_TRIM_US  = 0;

    // Channel width after reset: midpoint of the reset limits plus reset trim
    localparam logic [11:0] STORE_RST = 12'((RST_MIN_US + RST_MAX_US) / 2 + RST_TRIM_US);

    // Input request: tick (op 0) or channel width write (op 1)
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [2:0]  channel_sel;
        logic [11:0] width_us;
    } rcppm_in_t;

    typedef struct packed {
        logic       ppm_level;
        logic [3:0] slot_index;
        logic       slot_end;
    } rcppm_out_t;

    // Interval lengths derived from the configuration registers
    typedef struct packed {
        logic             settled;
        logic [CNT_W-1:0] sync_ticks;
        logic [CNT_W-1:0] gap_ticks;
    } rcppm_timing_t;

    // Microseconds to ticks; a zero-length interval becomes one tick
    function automatic logic [CNT_W-1:0] us_to_ticks(input logic [15:0] us,
                                                     input logic [6:0]  tpu);
        logic [22:0]      prod;
        logic [CNT_W-1:0] t;
        prod = 23'(us) * 23'(tpu);
        t    = prod[CNT_W-1:0];
        return (t == '0) ? CNT_W'(1) : t;
    endfunction

endpackage

/* hw/rtl/rcppm_cfg.sv */
`timescale 1ns / 1ps

module rcppm_cfg
    import rcppm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [2:0]    wr_addr,
    input  logic [15:0]   wr_data,
    output rcppm_timing_t timing
);

    localparam int ProdW = 13 + $clog2(NUM_CHANNELS + 1);
    localparam int SyncW = ((ProdW > 16) ? ProdW : 16) + 1;
    localparam logic [6:0] Tpu = 7'(TICKS_PER_US);

    logic [11:0] min_reg, max_reg, gap_reg;
    logic [15:0] frame_reg;
    logic [9:0]  trim_reg;

    // derived pipeline
    logic [12:0]      midgap_reg, midgap_next;
    logic [CNT_W-1:0] gap_ticks_reg, gap_ticks_next;
    logic [CNT_W-1:0] sync_ticks_reg, sync_ticks_next;
    logic [1:0]       busy_reg, busy_next;

    logic [12:0]        lim_sum;
    logic signed [13:0] mid_raw;
    logic [11:0]        mid_sat;
    logic [ProdW-1:0]   prod;
    logic signed [SyncW-1:0] sync_diff;
    logic [15:0]        sync_us;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= 12'(RST_MIN_US);
            max_reg   <= 12'(RST_MAX_US);
            gap_reg   <= 12'(RST_GAP_US);
            frame_reg <= 16'(RST_FRAME_US);
            trim_reg  <= 10'(RST_TRIM_US);
        end else if (wr_en) begin
            unique case (wr_addr)
                REG_MIN_WIDTH:   min_reg   <= wr_data[11:0];
                REG_MAX_WIDTH:   max_reg   <= wr_data[11:0];
                REG_GAP_WIDTH:   gap_reg   <= wr_data[11:0];
                REG_FRAME_WIDTH: frame_reg <= wr_data;
                REG_TRIM_CENTER: trim_reg  <= wr_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1: saturated midpoint plus gap, and gap in ticks
    always_comb begin
        lim_sum = 13'(min_reg) + 13'(max_reg);
        mid_raw = $signed({2'b00, lim_sum[12:1]}) + $signed({{4{trim_reg[9]}}, trim_reg});
        if (mid_raw[13]) begin
            mid_sat = '0;
        end else if (mid_raw[12]) begin
            mid_sat = 12'hFFF;
        end else begin
            mid_sat = mid_raw[11:0];
        end
        midgap_next    = 13'(mid_sat) + 13'(gap_reg);
        gap_ticks_next = us_to_ticks(16'(gap_reg), Tpu);
    end

    // stage 2: sync width, floored at one microsecond
    always_comb begin
        prod      = ProdW'(midgap_reg) * ProdW'(NUM_CHANNELS);
        sync_diff = $signed(SyncW'(frame_reg)) - $signed(SyncW'(prod));
        if (sync_diff < $signed(SyncW'(1))) begin
            sync_us = 16'd1;
        end else begin
            sync_us = sync_diff[15:0];
        end
        sync_ticks_next = us_to_ticks(sync_us, Tpu);
    end

    // busy until a write has passed midgap_reg and sync_ticks_reg
    always_comb begin
        if (wr_en) begin
            busy_next = 2'd2;
        end else if (busy_reg != 2'd0) begin
            busy_next = busy_reg - 2'd1;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 2'd2;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        midgap_reg     <= midgap_next;
        gap_ticks_reg  <= gap_ticks_next;
        sync_ticks_reg <= sync_ticks_next;
    end

    assign timing.settled    = (busy_reg == 2'd0);
    assign timing.sync_ticks = sync_ticks_reg;
    assign timing.gap_ticks  = gap_ticks_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (busy_reg == 2'd2))
        else $error("register write did not restart settling");

    assert property (@(posedge aclk) disable iff (!aresetn)
        timing.settled |-> (sync_ticks_reg != '0) && (gap_ticks_reg != '0))
        else $error("zero-length interval after settling");

endmodule

/* hw/rtl/rcppm_core.sv */
`timescale 1ns / 1ps

module rcppm_core
    import rcppm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  rcppm_in_t     in_item,
    input  rcppm_timing_t timing,
    output rcppm_out_t    result
);

    localparam int SlotW  = $clog2(NUM_CHANNELS + 1);
    localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [6:0] Tpu = 7'(TICKS_PER_US);
    localparam logic [CNT_W-1:0] CntRst = CNT_W'(RST_GAP_US * TICKS_PER_US);

    logic [11:0]      store_reg [NUM_CHANNELS];
    logic [11:0]      store_next [NUM_CHANNELS];
    logic [SlotW-1:0] slot_reg, slot_next;
    logic             level_reg, level_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             ended;
    logic             sel_ok;
    logic             slot_is_chan;
    logic [4:0]       sel_ext;
    logic [4:0]       slot_ext;
    logic [7:0]       slot_out;
    logic [ChIdxW-1:0] wr_idx, rd_idx;
    logic [CNT_W-1:0] pulse_ticks;

    always_comb begin
        sel_ext      = 5'(in_item.channel_sel);
        slot_ext     = 5'(slot_reg);
        wr_idx       = sel_ext[ChIdxW-1:0];
        rd_idx       = slot_ext[ChIdxW-1:0];
        sel_ok       = (32'(in_item.channel_sel) < NUM_CHANNELS);
        slot_is_chan = (32'(slot_reg) < NUM_CHANNELS);
        pulse_ticks  = slot_is_chan ? us_to_ticks(16'(store_reg[rd_idx]), Tpu)
                                    : timing.sync_ticks;

        store_next = store_reg;
        slot_next  = slot_reg;
        level_next = level_reg;
        cnt_next   = cnt_reg;
        ended      = 1'b0;

        if (accept) begin
            if (in_item.op == OP_WRITE) begin
                if (sel_ok) begin
                    store_next[wr_idx] = in_item.width_us;
                end
            end else if (cnt_reg > CNT_W'(1)) begin
                cnt_next = cnt_reg - CNT_W'(1);
            end else begin
                ended      = 1'b1;
                level_next = ~level_reg;
                if (!level_reg) begin
                    // rising edge: pulse of this slot
                    cnt_next = pulse_ticks;
                end else begin
                    // falling edge: next slot starts with its gap
                    slot_next = slot_is_chan ? SlotW'(slot_reg + 1'b1) : '0;
                    cnt_next  = timing.gap_ticks;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                store_reg[i] <= STORE_RST;
            end
            slot_reg  <= '0;
            level_reg <= 1'b0;
            cnt_reg   <= CntRst;
        end else begin
            store_reg <= store_next;
            slot_reg  <= slot_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign slot_out          = 8'(slot_next);
    assign result.ppm_level  = level_next;
    assign result.slot_index = slot_out[3:0];
    assign result.slot_end   = ended;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0)
        else $error("interval countdown reached zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) <= NUM_CHANNELS)
        else $error("slot counter beyond sync slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_item.op == OP_TICK) && (cnt_reg > CNT_W'(1))
        |=> (level_reg == $past(level_reg)) && (slot_reg == $past(slot_reg)))
        else $error("line moved before interval ended");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ended |=> (level_reg != $past(level_reg)))
        else $error("slot end without line toggle");

endmodule

/* hw/rtl/rc_ppm_frame_generator.sv */
`timescale 1ns / 1ps

// RC pulse-position frame generator.
//
// Input channel (s_*): one request per time base tick (op = tick) or a
// channel width write (op = write), taken one per cycle with s_ready high.
// Result channel (m_*): exactly one result per input request, giving the
// line level, the current slot (channels, then the sync slot) and whether
// that tick ended an interval.
// Config channel (cfg_*): index and data; cfg_ready is always high. After a
// write s_ready stays low while the sync and gap interval lengths are
// recomputed (saturated midpoint, then sync width).
// The result is registered at the edge that accepts the request and m_valid
// rises in the following cycle.
// A request is taken per cycle while s_ready is high; the slot/countdown
// update sits in a single register stage.
// Reset: synchronous, active low. Widths return to the midpoint of the reset
// limits, line low, slot 0, countdown loaded with the gap. s_ready stays low
// after reset while the interval lengths settle.
// Stall: while a result waits and m_ready is low, s_ready is low and the
// result is held; if settled and m_ready is high, one is taken per cycle.
module rc_ppm_frame_generator
    import rcppm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 1
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  rcppm_in_t   s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output rcppm_out_t  m_data,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    rcppm_timing_t timing;
    rcppm_out_t    result;
    logic          accept;
    logic          cfg_wr;

    logic          m_valid_reg, m_valid_next;
    rcppm_out_t    m_data_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // output register may refill in the same cycle it drains
    assign s_ready = timing.settled && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    rcppm_cfg #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TICKS_PER_US (TICKS_PER_US)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .timing  (timing)
    );

    rcppm_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TICKS_PER_US (TICKS_PER_US)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .timing  (timing),
        .result  (result)
    );

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("request taken while interval lengths settle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

endmodule

/* sim/rc_ppm_frame_generator_test.sv */
`timescale 1ns / 1ps

module rc_ppm_frame_generator_test;
    import rcppm_pkg::*;

    localparam int NUM_CHANNELS = 8;
    localparam int TICKS_PER_US = 1;
    localparam int NUM_REGS     = int'(REG_TRIM_CENTER) + 1;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 63;
    localparam int EXTREME_PH   = PHASES - 1;
    localparam int WIDE_PH      = 3;
    localparam int STEADY_PH    = 2;

    // One row of the directed plan: a request, how many times it is sent,
    // and an optional hand-written expected result.
    typedef struct packed {
        rcppm_in_t  req;
        logic [9:0] reps;
        logic       typed;
        rcppm_out_t want;
    } plan_row_t;

    localparam int PLAN_LEN = 15;

    // Runs under the first register set: midpoint pulled below zero (min = max = 0,
    // trim = -512), gap of 1 us, frame of 0 so the sync width clamps to 1 us.
    // The countdown after reset still holds the 300 us reset gap.
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // zero width: stretched to one tick when channel 0 fires
        '{'{OP_WRITE, 3'd0, 12'd0},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd1, 12'd1},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd2, 12'd2},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd3, 12'd3},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd4, 12'd4},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        // widest value, then overwritten before channel 5 comes around
        '{'{OP_WRITE, 3'd5, 12'hFFF},   10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd5, 12'd5},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd6, 12'd6},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_WRITE, 3'd7, 12'd7},     10'd1,   1'b1, '{1'b0, 4'd0, 1'b0}},
        // drain the reset gap; the ignored fields carry all ones
        '{'{OP_TICK,  3'd7, 12'hFFF},   10'd299, 1'b1, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_TICK,  3'd7, 12'hFFF},   10'd1,   1'b1, '{1'b1, 4'd0, 1'b1}},
        '{'{OP_TICK,  3'd0, 12'd0},     10'd1,   1'b1, '{1'b0, 4'd1, 1'b1}},
        '{'{OP_TICK,  3'd0, 12'd0},     10'd1,   1'b1, '{1'b1, 4'd1, 1'b1}},
        // rewrite a channel mid-frame, then run through sync and wrap
        '{'{OP_WRITE, 3'd2, 12'd0},     10'd1,   1'b0, '{1'b0, 4'd0, 1'b0}},
        '{'{OP_TICK,  3'd3, 12'h5A5},   10'd60,  1'b0, '{1'b0, 4'd0, 1'b0}}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    rcppm_in_t  s_data    = '0;
    logic       m_ready   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [2:0] cfg_addr  = REG_MIN_WIDTH;
    logic [15:0] cfg_data = '0;
    wire        s_ready;
    wire        m_valid;
    rcppm_out_t m_data;
    wire        cfg_ready;

    rc_ppm_frame_generator #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .TICKS_PER_US(TICKS_PER_US)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Shadow of the generator: registers, width store, line and counters
    logic [11:0]        min_us;
    logic [11:0]        max_us;
    logic [11:0]        gap_us;
    logic [15:0]        frame_us;
    logic signed [9:0]  trim_us;
    logic [11:0]        width_store [NUM_CHANNELS];
    logic [3:0]         slot;
    logic               level;
    logic [CNT_W-1:0]   countdown;

    rcppm_out_t  due_line_states [$];   // expected results, oldest first
    int unsigned fault_count = 0;
    bit          steady      = 1'b0;    // no idling on either side while set

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Generous ceiling on the whole run
    initial begin
        #400_000;
        $display("** rc_ppm_frame_generator: FAILED **");
        $finish;
    end

    // Midpoint of the limits plus trim, clamped to the 12-bit width range
    function automatic int mid_width_us();
        int m;
        m = (int'(min_us) + int'(max_us)) / 2 + int'(trim_us);
        if (m < 0)
            m = 0;
        if (m > 4095)
            m = 4095;
        return m;
    endfunction

    // Sync pulse: what is left of the frame, never shorter than 1 us
    function automatic int sync_width_us();
        int s;
        s = int'(frame_us) - NUM_CHANNELS * (mid_width_us() + int'(gap_us));
        return (s < 1) ? 1 : s;
    endfunction

    function automatic logic [CNT_W-1:0] us_ticks(input int us);
        logic [CNT_W-1:0] t;
        t = CNT_W'(us * TICKS_PER_US);
        return (t == '0) ? CNT_W'(1) : t;
    endfunction

    // Apply one request to the shadow and return the line state it leaves
    function automatic rcppm_out_t advance_line(input rcppm_in_t req);
        rcppm_out_t res;
        res.slot_end = 1'b0;
        if (req.op == OP_WRITE) begin
            if (int'(req.channel_sel) < NUM_CHANNELS)
                width_store[req.channel_sel] = req.width_us;
        end else if (countdown > CNT_W'(1)) begin
            countdown = countdown - CNT_W'(1);
        end else begin
            // interval over: toggle, then load pulse (rising) or gap (falling)
            res.slot_end = 1'b1;
            level = ~level;
            if (level) begin
                countdown = us_ticks((int'(slot) < NUM_CHANNELS) ?
                                     int'(width_store[slot]) : sync_width_us());
            end else begin
                slot      = (int'(slot) >= NUM_CHANNELS) ? 4'd0 : slot + 4'd1;
                countdown = us_ticks(int'(gap_us));
            end
        end
        res.ppm_level  = level;
        res.slot_index = slot;
        return res;
    endfunction

    // Write every register in index order; valid stays up across the burst
    task automatic load_registers(input logic [15:0] vals [NUM_REGS]);
        logic [2:0] addr;
        for (int i = 0; i < NUM_REGS; i++) begin
            addr = 3'(i);
            cfg_valid <= 1'b1;
            cfg_addr  <= addr;
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (addr)
                REG_MIN_WIDTH:   min_us   = vals[i][11:0];
                REG_MAX_WIDTH:   max_us   = vals[i][11:0];
                REG_GAP_WIDTH:   gap_us   = vals[i][11:0];
                REG_FRAME_WIDTH: frame_us = vals[i];
                REG_TRIM_CENTER: trim_us  = vals[i][9:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Offer one request, maybe after a one-cycle gap; on acceptance queue the
    // hand-written result if there is one, else the shadow's prediction.
    task automatic offer_request(input rcppm_in_t req, input bit typed,
                                 input rcppm_out_t want);
        rcppm_out_t predicted;
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_line(req);
        due_line_states.push_back(typed ? want : predicted);
    endtask

    // Wait until every expected result has come back
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (due_line_states.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side stalls at random with an 8 percent chance, never during the steady phase
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        rcppm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_line_states.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result: level %0d slot %0d end %0d",
                             m_data.ppm_level, m_data.slot_index, m_data.slot_end);
                fault_count++;
            end else begin
                want = due_line_states.pop_front();
                if (m_data.ppm_level !== want.ppm_level ||
                    m_data.slot_index !== want.slot_index ||
                    m_data.slot_end !== want.slot_end) begin
                    if (fault_count < 10)
                        $display({"mismatch: expected level %0d slot %0d end %0d,",
                                  " got level %0d slot %0d end %0d"},
                                 want.ppm_level, want.slot_index, want.slot_end,
                                 m_data.ppm_level, m_data.slot_index, m_data.slot_end);
                    fault_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [15:0] regs [NUM_REGS];
        rcppm_in_t   req;
        rcppm_out_t  none;
        int          trim;

        none = '0;

        // Shadow reset: reset register values, store at the saturated midpoint
        min_us   = 12'(RST_MIN_US);
        max_us   = 12'(RST_MAX_US);
        gap_us   = 12'(RST_GAP_US);
        frame_us = 16'(RST_FRAME_US);
        trim_us  = 10'(RST_TRIM_US);
        for (int c = 0; c < NUM_CHANNELS; c++)
            width_store[c] = 12'(mid_width_us());
        slot      = 4'd0;
        level     = 1'b0;
        countdown = us_ticks(int'(gap_us));

        do @(posedge aclk); while (!aresetn);

        // Low extremes: midpoint below zero, shortest gap, empty frame
        regs[REG_MIN_WIDTH]   = 16'd0;
        regs[REG_MAX_WIDTH]   = 16'd0;
        regs[REG_GAP_WIDTH]   = 16'd1;
        regs[REG_FRAME_WIDTH] = 16'd0;
        regs[REG_TRIM_CENTER] = 16'h0200;
        load_registers(regs);

        for (int r = 0; r < PLAN_LEN; r++)
            for (int k = 0; k < int'(DIRECTED_PLAN[r].reps); k++)
                offer_request(DIRECTED_PLAN[r].req, DIRECTED_PLAN[r].typed,
                              DIRECTED_PLAN[r].want);

        // Random phases, each under a fresh register set
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_quiet();
            if (phase == EXTREME_PH) begin
                // top of every range; midpoint clamps high
                regs[REG_MIN_WIDTH]   = 16'hFFF;
                regs[REG_MAX_WIDTH]   = 16'hFFF;
                regs[REG_GAP_WIDTH]   = 16'hFFF;
                regs[REG_FRAME_WIDTH] = 16'hFFFF;
                regs[REG_TRIM_CENTER] = 16'h01FF;
            end else if (phase == WIDE_PH) begin
                // any limits and trim; short frame so that sync often clamps
                regs[REG_MIN_WIDTH]   = 16'($urandom_range(0, 4095));
                regs[REG_MAX_WIDTH]   = 16'($urandom_range(0, 4095));
                regs[REG_GAP_WIDTH]   = 16'($urandom_range(1, 4));
                regs[REG_FRAME_WIDTH] = 16'($urandom_range(0, 300));
                regs[REG_TRIM_CENTER] = 16'($urandom_range(0, 1023));
            end else begin
                // short frames so many slots and wraps fit in a phase
                trim = int'($urandom_range(0, 10)) - 5;
                regs[REG_MIN_WIDTH]   = 16'($urandom_range(0, 20));
                regs[REG_MAX_WIDTH]   = 16'($urandom_range(0, 20));
                regs[REG_GAP_WIDTH]   = 16'($urandom_range(1, 4));
                regs[REG_FRAME_WIDTH] = 16'($urandom_range(0, 300));
                regs[REG_TRIM_CENTER] = 16'(trim) & 16'h03FF;
            end
            steady = (phase == STEADY_PH);
            load_registers(regs);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req = rcppm_in_t'(16'($urandom));
                if ($urandom_range(0, 99) < 15) begin
                    req.op = OP_WRITE;
                    // small widths keep frames short outside the extreme phase
                    if (phase != EXTREME_PH)
                        req.width_us = 12'($urandom_range(0, 9));
                end else begin
                    req.op = OP_TICK;
                end
                offer_request(req, 1'b0, none);
            end
        end

        steady = 1'b0;
        wait_quiet();
        repeat (8) @(posedge aclk);

        if (fault_count == 0)
            $display("** rc_ppm_frame_generator: PASSED **");
        else
            $display("** rc_ppm_frame_generator: FAILED **");
        $finish;
    end

endmodule
